// File: src/spp_pkg.sv
// Package for the sphere pair push-out block: widths, defaults and helper functions.
// No dependencies.
package spp_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int COORD_W = 32;
  localparam int RAD_W = 31;
  localparam int DIFF_W = 33;
  localparam int MAG_W = 32;
  localparam int SQ_W = 66;
  localparam int LEN_W = 33;
  localparam int RSUM_W = 32;
  localparam int PROD_W = 64;
  localparam int QUO_W = 64;

  typedef struct packed {
    logic signed [COORD_W-1:0] center_a_x;
    logic signed [COORD_W-1:0] center_a_y;
    logic signed [COORD_W-1:0] center_a_z;
    logic [RAD_W-1:0] radius_a;
    logic signed [COORD_W-1:0] center_b_x;
    logic signed [COORD_W-1:0] center_b_y;
    logic signed [COORD_W-1:0] center_b_z;
    logic [RAD_W-1:0] radius_b;
  } in_item_t;

  typedef struct packed {
    logic overlap_hit;
    logic signed [COORD_W-1:0] push_x;
    logic signed [COORD_W-1:0] push_y;
    logic signed [COORD_W-1:0] push_z;
  } out_item_t;

  // Saturate a signed magnitude to the 32-bit signed range.
  function automatic logic [COORD_W-1:0] sat_push(input logic neg,
                                                  input logic [QUO_W-1:0] m);
    logic [QUO_W-1:0] lim;
    logic [QUO_W-1:0] mm;
    begin
      lim = neg ? QUO_W'(64'h8000_0000) : QUO_W'(64'h7FFF_FFFF);
      mm = (m > lim) ? lim : m;
      sat_push = neg ? COORD_W'(-mm) : COORD_W'(mm);
    end
  endfunction

endpackage

// File: src/spp_if.sv
// Valid/ready channel interface carrying one payload of type T.
// Depends on nothing; the payload type is a parameter.
interface spp_if #(parameter type T = logic) (input logic clk);
  logic valid;
  logic ready;
  T data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: src/spp_sqrt.sv
// Pipelined bit-per-stage floor square root of the 66-bit distance square.
// Carries a side payload alongside; depends on spp_pkg.
module spp_sqrt #(
  parameter int SIDE_W = 8
) (
  input  logic clk,
  input  logic rst_n,
  input  logic en,
  input  logic in_vld,
  input  logic [spp_pkg::SQ_W-1:0] in_sq,
  input  logic [SIDE_W-1:0] in_side,
  output logic out_vld,
  output logic [spp_pkg::LEN_W-1:0] out_root,
  output logic [SIDE_W-1:0] out_side
);
  localparam int N = spp_pkg::LEN_W;
  localparam int RW = spp_pkg::LEN_W + 2;

  logic vld_r [N+1];
  logic [spp_pkg::SQ_W-1:0] sq_r [N+1];
  logic [RW-1:0] rem_r [N+1];
  logic [N-1:0] root_r [N+1];
  logic [SIDE_W-1:0] side_r [N+1];

  always_comb begin
    vld_r[0] = in_vld;
    sq_r[0] = in_sq;
    rem_r[0] = '0;
    root_r[0] = '0;
    side_r[0] = in_side;
  end

  // One result bit per stage, most significant pair first.
  for (genvar k = 0; k < N; k++) begin : g_stage
    logic [RW-1:0] rem_sh;
    logic [RW-1:0] trial;
    always_comb begin
      rem_sh = {rem_r[k][RW-3:0], sq_r[k][spp_pkg::SQ_W-1 -: 2]};
      trial = {root_r[k][N-2:0], 2'b01};
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k+1] <= 1'b0;
      end else if (en) begin
        vld_r[k+1] <= vld_r[k];
      end
      if (en) begin
        sq_r[k+1] <= {sq_r[k][spp_pkg::SQ_W-3:0], 2'b00};
        side_r[k+1] <= side_r[k];
        if (rem_sh >= trial) begin
          rem_r[k+1] <= rem_sh - trial;
          root_r[k+1] <= {root_r[k][N-2:0], 1'b1};
        end else begin
          rem_r[k+1] <= rem_sh;
          root_r[k+1] <= {root_r[k][N-2:0], 1'b0};
        end
      end
    end
  end

  assign out_vld = vld_r[N];
  assign out_root = root_r[N];
  assign out_side = side_r[N];
endmodule

// File: src/spp_div.sv
// Pipelined restoring divider, one quotient bit per stage, unsigned 64 by 33 bits.
// Carries a side payload alongside; depends on spp_pkg.
module spp_div #(
  parameter int SIDE_W = 8
) (
  input  logic clk,
  input  logic rst_n,
  input  logic en,
  input  logic in_vld,
  input  logic [spp_pkg::PROD_W-1:0] in_num,
  input  logic [spp_pkg::LEN_W-1:0] in_den,
  input  logic [SIDE_W-1:0] in_side,
  output logic out_vld,
  output logic [spp_pkg::QUO_W-1:0] out_quo,
  output logic [SIDE_W-1:0] out_side
);
  localparam int N = spp_pkg::PROD_W;
  localparam int RW = spp_pkg::LEN_W + 1;

  logic vld_r [N+1];
  logic [N-1:0] num_r [N+1];
  logic [spp_pkg::LEN_W-1:0] den_r [N+1];
  logic [RW-1:0] rem_r [N+1];
  logic [SIDE_W-1:0] side_r [N+1];

  always_comb begin
    vld_r[0] = in_vld;
    num_r[0] = in_num;
    den_r[0] = in_den;
    rem_r[0] = '0;
    side_r[0] = in_side;
  end

  // The numerator shifts out left while quotient bits shift in at the bottom.
  for (genvar k = 0; k < N; k++) begin : g_stage
    logic [RW-1:0] rem_sh;
    logic [RW-1:0] den_x;
    always_comb begin
      rem_sh = {rem_r[k][RW-2:0], num_r[k][N-1]};
      den_x = {1'b0, den_r[k]};
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k+1] <= 1'b0;
      end else if (en) begin
        vld_r[k+1] <= vld_r[k];
      end
      if (en) begin
        den_r[k+1] <= den_r[k];
        side_r[k+1] <= side_r[k];
        if (rem_sh >= den_x) begin
          rem_r[k+1] <= rem_sh - den_x;
          num_r[k+1] <= {num_r[k][N-2:0], 1'b1};
        end else begin
          rem_r[k+1] <= rem_sh;
          num_r[k+1] <= {num_r[k][N-2:0], 1'b0};
        end
      end
    end
  end

  assign out_vld = vld_r[N];
  assign out_quo = num_r[N];
  assign out_side = side_r[N];
endmodule

// File: src/sphere_pair_push_out.sv
// Sphere pair push-out: fully pipelined, one pair per cycle while the output
// is not stalled. Three stages form differences, squares and their sum, 33
// stages take the square root, two form depth times difference magnitude, 64
// stages divide (three lanes side by side) and one output register holds the
// result. A stalled output freezes the whole pipeline, so nothing is lost or
// repeated. Depends on spp_pkg, spp_if, spp_sqrt and spp_div.
module sphere_pair_push_out #(
  parameter int FRAC_BITS = spp_pkg::FRAC_BITS_DEF
) (
  input logic clk,
  input logic rst_n,
  spp_if.sink in_ch,
  spp_if.source out_ch
);
  localparam int DW = spp_pkg::DIFF_W;
  localparam int MW = spp_pkg::MAG_W + 1;
  localparam int RS = spp_pkg::RSUM_W;
  // Side payload through the root: three differences and the radius sum.
  localparam int S1 = 3 * DW + RS;
  // Side payload through the divider: sign and hit flag.
  localparam int S2 = 2;

  logic en;
  logic out_vld_r;
  spp_pkg::out_item_t out_r;

  // The format is fixed by the port widths; FRAC_BITS only names it.
  logic [7:0] frac_unused;
  assign frac_unused = 8'(FRAC_BITS);

  assign en = !out_vld_r || out_ch.ready;
  assign in_ch.ready = en;

  // Stage 1: differences and radius sum.
  logic v1_r;
  logic signed [DW-1:0] d1_r [3];
  logic [RS-1:0] rs1_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_ch.valid;
    end
    if (en) begin
      d1_r[0] <= DW'(in_ch.data.center_a_x) - DW'(in_ch.data.center_b_x);
      d1_r[1] <= DW'(in_ch.data.center_a_y) - DW'(in_ch.data.center_b_y);
      d1_r[2] <= DW'(in_ch.data.center_a_z) - DW'(in_ch.data.center_b_z);
      rs1_r <= RS'(in_ch.data.radius_a) + RS'(in_ch.data.radius_b);
    end
  end

  // Stage 2: squares of the magnitudes.
  logic v2_r;
  logic signed [DW-1:0] d2_r [3];
  logic [RS-1:0] rs2_r;
  logic [2*MW-1:0] sq2_r [3];
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
    if (en) begin
      rs2_r <= rs1_r;
      for (int i = 0; i < 3; i++) begin
        logic [MW-1:0] m;
        m = d1_r[i][DW-1] ? MW'(-d1_r[i]) : MW'(d1_r[i]);
        d2_r[i] <= d1_r[i];
        sq2_r[i] <= m * m;
      end
    end
  end

  // Stage 3: sum of squares.
  logic v3_r;
  logic [S1-1:0] side3_r;
  logic [spp_pkg::SQ_W-1:0] s3_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en) begin
      v3_r <= v2_r;
    end
    if (en) begin
      s3_r <= spp_pkg::SQ_W'(sq2_r[0]) + spp_pkg::SQ_W'(sq2_r[1]) +
              spp_pkg::SQ_W'(sq2_r[2]);
      side3_r <= {d2_r[0], d2_r[1], d2_r[2], rs2_r};
    end
  end

  logic v4;
  logic [spp_pkg::LEN_W-1:0] len4;
  logic [S1-1:0] side4;
  spp_sqrt #(.SIDE_W(S1)) u_sqrt (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_vld(v3_r), .in_sq(s3_r), .in_side(side3_r),
    .out_vld(v4), .out_root(len4), .out_side(side4)
  );

  // Stage 5: hit decision and depth.
  logic v5_r;
  logic hit5_r;
  logic [spp_pkg::LEN_W-1:0] len5_r;
  logic [RS-1:0] dep5_r;
  logic [MW-1:0] m5_r [3];
  logic [2:0] neg5_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else if (en) begin
      v5_r <= v4;
    end
    if (en) begin
      logic [RS-1:0] rs;
      logic signed [DW-1:0] dd [3];
      {dd[0], dd[1], dd[2], rs} = side4;
      hit5_r <= (len4 != '0) && (len4 < spp_pkg::LEN_W'(rs));
      len5_r <= len4;
      dep5_r <= rs - RS'(len4);
      for (int i = 0; i < 3; i++) begin
        m5_r[i] <= dd[i][DW-1] ? MW'(-dd[i]) : MW'(dd[i]);
        neg5_r[i] <= dd[i][DW-1];
      end
    end
  end

  // Stage 6: magnitude times depth, fits in 64 bits.
  logic v6_r;
  logic hit6_r;
  logic [spp_pkg::LEN_W-1:0] len6_r;
  logic [spp_pkg::PROD_W-1:0] p6_r [3];
  logic [2:0] neg6_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v6_r <= 1'b0;
    end else if (en) begin
      v6_r <= v5_r;
    end
    if (en) begin
      hit6_r <= hit5_r;
      // A zero length makes the divisor safe; the result is discarded.
      len6_r <= (len5_r == '0) ? spp_pkg::LEN_W'(1) : len5_r;
      neg6_r <= neg5_r;
      for (int i = 0; i < 3; i++) begin
        p6_r[i] <= spp_pkg::PROD_W'(m5_r[i]) * spp_pkg::PROD_W'(dep5_r);
      end
    end
  end

  logic [2:0] v7;
  logic [spp_pkg::QUO_W-1:0] q7 [3];
  logic [S2-1:0] side7 [3];
  for (genvar i = 0; i < 3; i++) begin : g_lane
    spp_div #(.SIDE_W(S2)) u_div (
      .clk(clk), .rst_n(rst_n), .en(en),
      .in_vld(v6_r), .in_num(p6_r[i]), .in_den(len6_r),
      .in_side({neg6_r[i], hit6_r}),
      .out_vld(v7[i]), .out_quo(q7[i]), .out_side(side7[i])
    );
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= v7[0];
    end
    if (en) begin
      out_r.overlap_hit <= side7[0][0];
      out_r.push_x <= side7[0][0] ? spp_pkg::sat_push(side7[0][1], q7[0]) : '0;
      out_r.push_y <= side7[1][0] ? spp_pkg::sat_push(side7[1][1], q7[1]) : '0;
      out_r.push_z <= side7[2][0] ? spp_pkg::sat_push(side7[2][1], q7[2]) : '0;
    end
  end

  assign out_ch.valid = out_vld_r;
  assign out_ch.data = out_r;

`ifndef NO_ASSERTIONS
  a_lanes_agree: assert property (@(posedge clk) disable iff (!rst_n)
    v7[0] == v7[1] && v7[1] == v7[2]) else $error("divider lanes out of step");
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && !out_r.overlap_hit |-> out_r.push_x == '0 && out_r.push_y == '0
      && out_r.push_z == '0) else $error("miss with nonzero push");
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && !out_ch.ready |=> out_vld_r && $stable(out_r))
    else $error("stalled result changed");
  a_ready_rule: assert property (@(posedge clk) disable iff (!rst_n)
    !out_vld_r |-> in_ch.ready) else $error("pipeline blocked while output empty");
`endif
endmodule

// File: sim/sphere_pair_push_out_tb.sv
// Self-checking testbench for the sphere pair push-out block: drives sphere pairs,
// predicts overlap and push-out vectors, and compares every result transaction.
// Depends on spp_pkg, spp_if and sphere_pair_push_out.
module sphere_pair_push_out_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY = 110;
  localparam longint CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  spp_if #(.T(spp_pkg::in_item_t)) pair_ch (clk);
  spp_if #(.T(spp_pkg::out_item_t)) push_ch (clk);

  sphere_pair_push_out dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(pair_ch.sink),
    .out_ch(push_ch.source)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  spp_pkg::in_item_t pair_queue[$];
  spp_pkg::out_item_t push_expected[$];
  int mismatches = 0;
  longint cycle_count = 0;
  bit feed_done = 0;
  bit quiet = 0;
  bit hold_long = 0;
  int send_gap = 0;
  int recv_gap = 0;
  int hold_cnt = 0;

  // Floor square root of a 66-bit value, one result bit per step.
  function automatic logic [spp_pkg::LEN_W-1:0] floor_root(
      input logic [spp_pkg::SQ_W-1:0] s);
    logic [spp_pkg::LEN_W-1:0] root;
    logic [spp_pkg::SQ_W+1:0] rem;
    logic [spp_pkg::SQ_W+1:0] trial;
    root = '0;
    rem = '0;
    for (int k = 32; k >= 0; k--) begin
      rem = (rem << 2) | s[2*k +: 2];
      trial = ({{(spp_pkg::SQ_W+2-spp_pkg::LEN_W){1'b0}}, root} << 2) | 1;
      if (rem >= trial) begin
        rem = rem - trial;
        root = (root << 1) | 1'b1;
      end else begin
        root = root << 1;
      end
    end
    return root;
  endfunction

  function automatic logic signed [spp_pkg::COORD_W-1:0] push_component(
      input logic signed [spp_pkg::DIFF_W-1:0] d, input logic [63:0] depth,
      input logic [63:0] len);
    logic [63:0] mag;
    logic [63:0] q;
    mag = d < 0 ? -64'(d) : 64'(d);
    q = (mag * depth) / len;
    if (d < 0) begin
      if (q > 64'h8000_0000) q = 64'h8000_0000;
      return spp_pkg::COORD_W'(-q);
    end
    if (q > 64'h7FFF_FFFF) q = 64'h7FFF_FFFF;
    return spp_pkg::COORD_W'(q);
  endfunction

  function automatic spp_pkg::out_item_t predict_push(input spp_pkg::in_item_t p);
    spp_pkg::out_item_t r;
    logic signed [spp_pkg::DIFF_W-1:0] dx, dy, dz;
    logic [spp_pkg::SQ_W-1:0] s;
    logic [63:0] len, rsum;
    dx = spp_pkg::DIFF_W'(p.center_a_x) - spp_pkg::DIFF_W'(p.center_b_x);
    dy = spp_pkg::DIFF_W'(p.center_a_y) - spp_pkg::DIFF_W'(p.center_b_y);
    dz = spp_pkg::DIFF_W'(p.center_a_z) - spp_pkg::DIFF_W'(p.center_b_z);
    s = spp_pkg::SQ_W'(66'(signed'(dx)) * 66'(signed'(dx)))
      + spp_pkg::SQ_W'(66'(signed'(dy)) * 66'(signed'(dy)))
      + spp_pkg::SQ_W'(66'(signed'(dz)) * 66'(signed'(dz)));
    len = 64'(floor_root(s));
    rsum = 64'(p.radius_a) + 64'(p.radius_b);
    r = '0;
    if (len != 0 && len < rsum) begin
      r.overlap_hit = 1'b1;
      r.push_x = push_component(dx, rsum - len, len);
      r.push_y = push_component(dy, rsum - len, len);
      r.push_z = push_component(dz, rsum - len, len);
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch %s: got %0h expected %0h", what, got, want);
    mismatches++;
  endtask

  // Driver: offer pending pairs, with random idle bursts.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (!rst_n) begin
      pair_ch.valid <= 1'b0;
    end else begin
      if (pair_ch.valid && pair_ch.ready) begin
        push_expected.push_back(predict_push(pair_ch.data));
        void'(pair_queue.pop_front());
      end
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        pair_ch.valid <= 1'b0;
      end else if (!quiet && !hold_long && $urandom_range(0, 19) == 0
                   && !(pair_ch.valid && !pair_ch.ready)) begin
        send_gap <= $urandom_range(1, 16) - 1;
        pair_ch.valid <= 1'b0;
      end else begin
        automatic int n = pair_queue.size() - ((pair_ch.valid && pair_ch.ready) ? 1 : 0);
        if (n > 0) begin
          pair_ch.valid <= 1'b1;
          pair_ch.data <= pair_queue[(pair_ch.valid && pair_ch.ready) ? 1 : 0];
        end else begin
          pair_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random stalls plus one long hold-off to fill the pipeline.
  always @(posedge clk) begin
    if (!rst_n) begin
      push_ch.ready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      push_ch.ready <= 1'b0;
    end else if (hold_long) begin
      hold_long <= 1'b0;
      hold_cnt <= 300;
      push_ch.ready <= 1'b0;
    end else if (recv_gap > 0) begin
      recv_gap <= recv_gap - 1;
      push_ch.ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 19) == 0) begin
      recv_gap <= $urandom_range(1, 16) - 1;
      push_ch.ready <= 1'b0;
    end else begin
      push_ch.ready <= 1'b1;
    end
  end

  // Monitor.
  always @(posedge clk) begin
    if (rst_n && push_ch.valid && push_ch.ready) begin
      if (push_expected.size() == 0) begin
        report_mismatch("unexpected result", 64'(push_ch.data), 0);
      end else begin
        automatic spp_pkg::out_item_t want = push_expected.pop_front();
        if (push_ch.data.overlap_hit !== want.overlap_hit)
          report_mismatch("overlap_hit", push_ch.data.overlap_hit, want.overlap_hit);
        if (push_ch.data.push_x !== want.push_x)
          report_mismatch("push_x", push_ch.data.push_x, want.push_x);
        if (push_ch.data.push_y !== want.push_y)
          report_mismatch("push_y", push_ch.data.push_y, want.push_y);
        if (push_ch.data.push_z !== want.push_z)
          report_mismatch("push_z", push_ch.data.push_z, want.push_z);
      end
    end
  end

  function automatic logic signed [spp_pkg::COORD_W-1:0] rand_coord();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return spp_pkg::COORD_W'(signed'($urandom_range(0, 2000000)) - 1000000);
      2: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return spp_pkg::COORD_W'(signed'($urandom_range(0, 20000)) - 10000);
    endcase
  endfunction

  function automatic spp_pkg::in_item_t random_pair();
    spp_pkg::in_item_t p;
    logic signed [spp_pkg::COORD_W-1:0] ox, oy, oz;
    p.center_a_x = rand_coord();
    p.center_a_y = rand_coord();
    p.center_a_z = rand_coord();
    p.radius_a = $urandom_range(0, 3) == 0 ? spp_pkg::RAD_W'($urandom())
                                           : spp_pkg::RAD_W'($urandom_range(0, 4000000));
    // Most pairs place B near A so overlaps are common.
    if ($urandom_range(0, 3) != 0) begin
      ox = spp_pkg::COORD_W'(signed'($urandom_range(0, 4000000)) - 2000000);
      oy = spp_pkg::COORD_W'(signed'($urandom_range(0, 4000000)) - 2000000);
      oz = spp_pkg::COORD_W'(signed'($urandom_range(0, 4000000)) - 2000000);
      p.center_b_x = p.center_a_x + ox;
      p.center_b_y = p.center_a_y + oy;
      p.center_b_z = p.center_a_z + oz;
    end else begin
      p.center_b_x = rand_coord();
      p.center_b_y = rand_coord();
      p.center_b_z = rand_coord();
    end
    p.radius_b = $urandom_range(0, 3) == 0 ? spp_pkg::RAD_W'($urandom())
                                           : spp_pkg::RAD_W'($urandom_range(0, 4000000));
    return p;
  endfunction

  function automatic spp_pkg::in_item_t make_pair(input logic signed [31:0] ax, ay, az,
      input logic [30:0] ra, input logic signed [31:0] bx, by, bz,
      input logic [30:0] rb);
    spp_pkg::in_item_t p;
    p.center_a_x = ax; p.center_a_y = ay; p.center_a_z = az; p.radius_a = ra;
    p.center_b_x = bx; p.center_b_y = by; p.center_b_z = bz; p.radius_b = rb;
    return p;
  endfunction

  initial begin
    pair_ch.valid = 1'b0;
    pair_ch.data = '0;
    push_ch.ready = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    // Directed: coincident centers, touching, just inside, extremes, saturation.
    pair_queue.push_back(make_pair(0, 0, 0, 31'h10000, 0, 0, 0, 31'h10000));
    pair_queue.push_back(make_pair(32'h20000, 0, 0, 31'h10000, 0, 0, 0, 31'h10000));
    pair_queue.push_back(make_pair(32'h1FFFF, 0, 0, 31'h10000, 0, 0, 0, 31'h10000));
    pair_queue.push_back(make_pair(0, 32'h10000, 0, 31'h10000, 0, 0, 0, 31'h10000));
    pair_queue.push_back(make_pair(0, 0, -32'sh10000, 31'h10000, 0, 0, 0, 31'h10000));
    pair_queue.push_back(make_pair(1, 0, 0, 31'h7FFF_FFFF, 0, 0, 0, 31'h7FFF_FFFF));
    pair_queue.push_back(make_pair(-1, 0, 0, 31'h7FFF_FFFF, 0, 0, 0, 31'h7FFF_FFFF));
    pair_queue.push_back(make_pair(1, 1, 1, 31'h7FFF_FFFF, 0, 0, 0, 31'h7FFF_FFFF));
    pair_queue.push_back(make_pair(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                         31'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                         31'h7FFF_FFFF));
    pair_queue.push_back(make_pair(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                         31'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                         31'h7FFF_FFFF));
    pair_queue.push_back(make_pair(32'h8000_0000, 0, 0, 31'h7FFF_FFFF, 32'h7FFF_FFFF,
                         0, 0, 31'h7FFF_FFFF));
    pair_queue.push_back(make_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                         31'h5555_5555, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                         31'h2AAA_AAAA));
    pair_queue.push_back(make_pair(3, -4, 0, 31'h0, 0, 0, 0, 31'h6));
    pair_queue.push_back(make_pair(3, -4, 0, 31'h5, 0, 0, 0, 31'h0));
    pair_queue.push_back(make_pair(0, 0, 0, 31'h0, 0, 0, 0, 31'h0));
    pair_queue.push_back(make_pair(0, 0, 0, 31'h2AAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA,
                         32'h5555_5555, 31'h5555_5555));
    for (int i = 0; i < 300; i++) pair_queue.push_back(random_pair());
    wait (pair_queue.size() < 10);
    // Hold the receiver off while the sender keeps offering pairs.
    for (int i = 0; i < 400; i++) pair_queue.push_back(random_pair());
    @(posedge clk);
    hold_long <= 1'b1;
    wait (pair_queue.size() < 10);
    quiet <= 1'b1;
    for (int i = 0; i < 250; i++) pair_queue.push_back(random_pair());
    wait (pair_queue.size() == 0);
    feed_done <= 1'b1;
  end

  initial begin
    wait (feed_done);
    wait (push_expected.size() == 0);
    repeat (LATENCY + 20) @(posedge clk);
    if (mismatches == 0 && push_expected.size() == 0)
      $display("sphere_pair_push_out_tb OK");
    else
      $display("sphere_pair_push_out_tb NOT OK");
    $finish;
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("timeout after %0d cycles", cycle_count);
    $display("sphere_pair_push_out_tb NOT OK");
    $finish;
  end
endmodule

// File: sphere_pair_push_out.f
src/spp_pkg.sv
src/spp_if.sv
src/spp_sqrt.sv
src/spp_div.sv
src/sphere_pair_push_out.sv
sim/sphere_pair_push_out_tb.sv
